[design/led_pwm_pkg.sv]
// Shared constants, function codes and field widths of the LED PWM and blink controller.
// No dependencies; imported by the controller top level and its checker.
package led_pwm_pkg;

  localparam int NUM_LEDS       = 8;
  localparam int PWM_PERIOD     = 16;
  localparam int BRIGHTNESS_MAX = 16;

  localparam int PWM_W = (PWM_PERIOD > 1) ? $clog2(PWM_PERIOD) : 1;
  localparam int IDX_W = 3;

  localparam int FUNC_W  = 4;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK      = 4'd0,
    FUNC_ENABLE    = 4'd1,
    FUNC_DISABLE   = 4'd2,
    FUNC_TOGGLE    = 4'd3,
    FUNC_SET_BRT   = 4'd4,
    FUNC_STEP_BRT  = 4'd5,
    FUNC_BLINK     = 4'd6,
    FUNC_PERIOD    = 4'd7,
    FUNC_THRESHOLD = 4'd8,
    FUNC_READ      = 4'd9
  } func_e;

endpackage

[design/led_pwm_blink_controller.sv]
// Top level of the LED PWM dimming and blink controller: sequencer, per-LED state
// and the shared per-LED tick unit. Depends on led_pwm_pkg.

// Each input transaction carries a function code in tuser and returns exactly one
// result transaction. A tick walks the LEDs one per cycle through a single step unit
// (blink counter increment, threshold and period compares, run countdown, PWM
// compare) in the tick state, then loads its result in the done state before it
// returns to idle. Every other command reads or updates one LED's settings in the
// command state and then loads its result in the done state. A result that still
// waits on the master side holds the next result back in the done state until it
// is taken. A new transaction is accepted once the block is back in idle, even
// while the previous result still waits on the master side.
// led_pattern reports the pattern from the most recent tick; read fields are zero
// for every code but read, and commands to an LED index at or above NUM_LEDS do
// nothing.
module led_pwm_blink_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [2:0] led_index, [10:3] brightness_value, [18:11] brightness_step,
  // [34:19] on_ticks, [50:35] off_ticks, [58:51] blink_count,
  // [74:59] new_period, [90:75] threshold_ticks, [95:91] zero
  input  logic [led_pwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [3:0] func
  input  logic [led_pwm_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [7:0] led_pattern, [15:8] enabled_leds, [23:16] blinking_leds,
  // [31:24] read_brightness, [47:32] read_period, [63:48] read_threshold
  output logic [led_pwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import led_pwm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_CMD,
    ST_DONE
  } state_e;

  state_e state_q;

  // latched transaction
  func_e             func_q;
  logic [IDX_W-1:0]  idx_q;
  logic [7:0]        brt_val_q;
  logic signed [7:0] brt_step_q;
  logic [15:0]       on_q;
  logic [15:0]       off_q;
  logic [7:0]        count_q;
  logic [15:0]       period_in_q;
  logic [15:0]       thr_in_q;

  // global state
  logic [PWM_W-1:0] pwm_q;
  logic [7:0]       en_q, en_d;
  logic [7:0]       blink_q, blink_d;
  logic [7:0]       repeat_q;
  logic [7:0]       last_pat_q;
  logic [7:0]       pat_q, pat_d;
  logic [IDX_W-1:0] led_cnt_q;

  // per-LED state
  logic [7:0]  brt_q    [NUM_LEDS];
  logic [15:0] btick_q  [NUM_LEDS];
  logic [15:0] bperiod_q[NUM_LEDS];
  logic [15:0] thr_q    [NUM_LEDS];
  logic [7:0]  cycles_q [NUM_LEDS];

  // read results
  logic [7:0]  rd_brt_q;
  logic [15:0] rd_period_q;
  logic [15:0] rd_thr_q;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic             accept;
  logic [IDX_W-1:0] addr;
  logic             idx_ok;
  logic [7:0]       addr_bit;
  logic             last_led;

  // shared step unit
  logic [7:0]        cur_brt;
  logic [15:0]       cur_tick;
  logic [15:0]       cur_period;
  logic [15:0]       cur_thr;
  logic [7:0]        cur_cycles;
  logic              cur_blink;
  logic [15:0]       tick_inc;
  logic              tick_wrap;
  logic [7:0]        cycles_dec;
  logic              run_end;
  logic              led_dark;
  logic signed [9:0] brt_sum;
  logic [7:0]        brt_sat;
  logic [PWM_W-1:0]  pwm_next;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign addr     = (state_q == ST_TICK) ? led_cnt_q : idx_q;
  assign idx_ok   = ({1'b0, idx_q} < (IDX_W + 1)'(NUM_LEDS));
  assign addr_bit = 8'(1) << addr;
  assign last_led = (led_cnt_q == IDX_W'(NUM_LEDS - 1));

  assign pwm_next = (pwm_q == PWM_W'(PWM_PERIOD - 1)) ? '0 : pwm_q + PWM_W'(1);

  always_comb begin
    cur_brt    = brt_q[addr];
    cur_tick   = btick_q[addr];
    cur_period = bperiod_q[addr];
    cur_thr    = thr_q[addr];
    cur_cycles = cycles_q[addr];
    cur_blink  = blink_q[addr];

    tick_inc   = cur_tick + 16'd1;
    tick_wrap  = (tick_inc == cur_period);
    cycles_dec = repeat_q[addr] ? cur_cycles : cur_cycles - 8'd1;
    run_end    = cur_blink && tick_wrap && (cycles_dec == 8'd0);
    led_dark   = (cur_blink && ((tick_inc >= cur_thr) || run_end))
                 || (cur_brt <= 8'(pwm_q));

    brt_sum = $signed({2'b00, cur_brt}) + $signed({{2{brt_step_q[7]}}, brt_step_q});
    if (brt_sum[9]) begin
      brt_sat = 8'd0;
    end else if (brt_sum > $signed(10'(BRIGHTNESS_MAX))) begin
      brt_sat = 8'(BRIGHTNESS_MAX);
    end else begin
      brt_sat = brt_sum[7:0];
    end
  end

  // mask updates from the tick step and from enable, disable, toggle and blink commands
  always_comb begin
    en_d    = en_q;
    blink_d = blink_q;
    pat_d   = pat_q;
    if (accept && func_e'(s_axis_tuser_i) == FUNC_TICK) begin
      // start every tick with all LEDs lit
      pat_d = '1;
    end else if (state_q == ST_TICK) begin
      pat_d = led_dark ? (pat_q & ~addr_bit) : (pat_q | addr_bit);
      if (run_end) begin
        en_d    = en_q & ~addr_bit;
        blink_d = blink_q & ~addr_bit;
      end
    end else if (state_q == ST_CMD && idx_ok) begin
      unique case (func_q)
        FUNC_ENABLE:  en_d    = en_q | addr_bit;
        FUNC_DISABLE: en_d    = en_q & ~addr_bit;
        FUNC_TOGGLE:  en_d    = en_q ^ addr_bit;
        FUNC_BLINK:   blink_d = blink_q | addr_bit;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= FUNC_TICK;
      idx_q       <= '0;
      brt_val_q   <= '0;
      brt_step_q  <= '0;
      on_q        <= '0;
      off_q       <= '0;
      count_q     <= '0;
      period_in_q <= '0;
      thr_in_q    <= '0;
      pwm_q       <= '0;
      en_q        <= '0;
      blink_q     <= '0;
      repeat_q    <= '0;
      last_pat_q  <= '0;
      pat_q       <= '0;
      led_cnt_q   <= '0;
      rd_brt_q    <= '0;
      rd_period_q <= '0;
      rd_thr_q    <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        brt_q[i]     <= '0;
        btick_q[i]   <= '0;
        bperiod_q[i] <= '0;
        thr_q[i]     <= '0;
        cycles_q[i]  <= '0;
      end
    end else begin
      en_q    <= en_d;
      blink_q <= blink_d;
      pat_q   <= pat_d;

      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q      <= func_e'(s_axis_tuser_i);
            idx_q       <= s_axis_tdata_i[2:0];
            brt_val_q   <= s_axis_tdata_i[10:3];
            brt_step_q  <= s_axis_tdata_i[18:11];
            on_q        <= s_axis_tdata_i[34:19];
            off_q       <= s_axis_tdata_i[50:35];
            count_q     <= s_axis_tdata_i[58:51];
            period_in_q <= s_axis_tdata_i[74:59];
            thr_in_q    <= s_axis_tdata_i[90:75];
            rd_brt_q    <= '0;
            rd_period_q <= '0;
            rd_thr_q    <= '0;
            if (func_e'(s_axis_tuser_i) == FUNC_TICK) begin
              pwm_q     <= pwm_next;
              led_cnt_q <= '0;
              state_q   <= ST_TICK;
            end else begin
              state_q <= ST_CMD;
            end
          end
        end

        ST_TICK: begin
          if (cur_blink) begin
            btick_q[addr] <= tick_wrap ? 16'd0 : tick_inc;
            if (tick_wrap) begin
              cycles_q[addr] <= cycles_dec;
            end
          end
          if (last_led) begin
            last_pat_q <= pat_d & en_d;
            state_q    <= ST_DONE;
          end else begin
            led_cnt_q <= led_cnt_q + IDX_W'(1);
          end
        end

        ST_CMD: begin
          if (idx_ok) begin
            unique case (func_q)
              FUNC_SET_BRT:   brt_q[addr] <= brt_val_q;
              FUNC_STEP_BRT:  brt_q[addr] <= brt_sat;
              FUNC_BLINK: begin
                bperiod_q[addr] <= on_q + off_q;
                thr_q[addr]     <= on_q;
                btick_q[addr]   <= '0;
                if (count_q == 8'd0) begin
                  cycles_q[addr] <= 8'd1;
                  repeat_q       <= repeat_q | addr_bit;
                end else begin
                  cycles_q[addr] <= count_q;
                  repeat_q       <= repeat_q & ~addr_bit;
                end
              end
              FUNC_PERIOD:    bperiod_q[addr] <= period_in_q;
              FUNC_THRESHOLD: thr_q[addr]     <= thr_in_q;
              FUNC_READ: begin
                rd_brt_q    <= cur_brt;
                rd_period_q <= cur_period;
                rd_thr_q    <= cur_thr;
              end
              default: ;
            endcase
          end
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          // hold until the previous result has left the output register
          if (!out_valid_q || m_axis_tready_i) begin
            out_data_q <= {rd_thr_q, rd_period_q, rd_brt_q, blink_q, en_q, last_pat_q};
            state_q    <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/led_pwm_checker.sv]
// Port-level checker for the LED PWM and blink controller, bound to its top level.
// Depends on led_pwm_pkg and led_pwm_blink_controller.
module led_pwm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic [led_pwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [led_pwm_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [led_pwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import led_pwm_pkg::*;

  // busy right after a transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while still working on the previous transaction");

  // a result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without a transaction in progress");

  // accepting a transaction leaves a valid result on the output unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o || $stable(m_axis_tdata_o))
    else $error("result changed right after an input was accepted");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

endmodule

bind led_pwm_blink_controller led_pwm_checker u_led_pwm_checker (.*);

[bench/led_pwm_blink_controller_tb.sv]
// Self-checking bench for the LED PWM and blink controller: a directed table, then
// random command streams under varying stall patterns. Depends on led_pwm_pkg and the RTL.
module led_pwm_blink_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import led_pwm_pkg::*;

  localparam int RAND_ITEMS     = 1400;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int RX_HOLD_AFTER  = 60;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_ROWS       = 26;

  // codes outside the defined set; the block must leave its state alone on these
  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 4'd10;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 4'd15;

  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] thr;
    logic [15:0] per;
    logic [7:0]  cnt;
    logic [15:0] off_t;
    logic [15:0] on_t;
    logic [7:0]  step;
    logic [7:0]  bval;
    logic [2:0]  idx;
  } led_cmd_t;

  typedef struct packed {
    logic [15:0] rd_thr;
    logic [15:0] rd_period;
    logic [7:0]  rd_brt;
    logic [7:0]  blinking;
    logic [7:0]  enabled;
    logic [7:0]  pattern;
  } led_status_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [2:0]        idx;
    logic [7:0]        bval;
    logic [7:0]        step;
    logic [15:0]       on_t;
    logic [15:0]       off_t;
    logic [7:0]        cnt;
    logic [15:0]       per;
    logic [15:0]       thr;
    bit                typed;
    logic [63:0]       want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni           = 1'b0;
  logic                   s_axis_tvalid_i  = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i   = '0;
  logic [FUNC_W-1:0]      s_axis_tuser_i   = FUNC_TICK;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // shadow copy of the controller state
  logic [7:0]  pwm_cnt;
  logic [7:0]  en_mask;
  logic [7:0]  blk_mask;
  logic [7:0]  rpt_mask;
  logic [7:0]  pattern_q;
  logic [7:0]  brt      [NUM_LEDS];
  logic [15:0] btick    [NUM_LEDS];
  logic [15:0] bper     [NUM_LEDS];
  logic [15:0] lit_thr  [NUM_LEDS];
  logic [7:0]  runs_left[NUM_LEDS];

  led_status_t pending_status[$];
  dir_row_t    dir_tab[DIR_ROWS];

  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  int  rand_sent = 0;
  int  sent_cnt = 0;
  int  checked_cnt = 0;
  int  err_cnt = 0;
  int  tick_cnt = 0;
  int  read_cnt = 0;
  int  runs_done = 0;
  int  cyc_cnt = 0;

  led_pwm_blink_controller uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // apply one command to the shadow state and return the status it reports
  function automatic led_status_t apply_led_cmd(input logic [FUNC_W-1:0] fn,
                                                input led_cmd_t c);
    led_status_t r;
    logic [7:0]  pat;
    logic [7:0]  bitm;
    int          nb;
    logic        ok;
    r    = '0;
    ok   = int'(c.idx) < NUM_LEDS;
    bitm = 8'(1 << c.idx);
    if (fn == FUNC_TICK) begin
      tick_cnt++;
      pat = 8'hff;
      pwm_cnt = 8'((int'(pwm_cnt) + 1) % PWM_PERIOD);
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (blk_mask[i]) begin
          btick[i] = btick[i] + 16'd1;
          if (!(btick[i] < lit_thr[i])) pat[i] = 1'b0;
          if (btick[i] == bper[i]) begin
            btick[i] = '0;
            if (!rpt_mask[i]) runs_left[i] = runs_left[i] - 8'd1;
            // finite run over: drop the LED out of blink mode and disable it
            if (runs_left[i] == 8'd0) begin
              pat[i]      = 1'b0;
              en_mask[i]  = 1'b0;
              blk_mask[i] = 1'b0;
              runs_done++;
            end
          end
        end
        if (brt[i] <= pwm_cnt) pat[i] = 1'b0;
      end
      pattern_q = pat & en_mask;
    end else if (ok) begin
      case (fn)
        FUNC_ENABLE:    en_mask = en_mask | bitm;
        FUNC_DISABLE:   en_mask = en_mask & ~bitm;
        FUNC_TOGGLE:    en_mask = en_mask ^ bitm;
        FUNC_SET_BRT:   brt[c.idx] = c.bval;
        FUNC_STEP_BRT: begin
          nb = int'(brt[c.idx]) + int'($signed(c.step));
          if (nb < 0) nb = 0;
          else if (nb > BRIGHTNESS_MAX) nb = BRIGHTNESS_MAX;
          brt[c.idx] = 8'(nb);
        end
        FUNC_BLINK: begin
          bper[c.idx]    = c.on_t + c.off_t;
          lit_thr[c.idx] = c.on_t;
          btick[c.idx]   = '0;
          if (c.cnt == 8'd0) begin
            runs_left[c.idx] = 8'd1;
            rpt_mask = rpt_mask | bitm;
          end else begin
            runs_left[c.idx] = c.cnt;
            rpt_mask = rpt_mask & ~bitm;
          end
          blk_mask = blk_mask | bitm;
        end
        FUNC_PERIOD:    bper[c.idx] = c.per;
        FUNC_THRESHOLD: lit_thr[c.idx] = c.thr;
        FUNC_READ: begin
          read_cnt++;
          r.rd_brt    = brt[c.idx];
          r.rd_period = bper[c.idx];
          r.rd_thr    = lit_thr[c.idx];
        end
        default: ;
      endcase
    end
    r.pattern  = pattern_q;
    r.enabled  = en_mask;
    r.blinking = blk_mask;
    return r;
  endfunction

  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input led_cmd_t c,
                          input bit typed, input led_status_t want);
    led_status_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tuser_i  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = apply_led_cmd(fn, c);
    pending_status.push_back(typed ? want : r);
    sent_cnt++;
  endtask

  // result side: random backpressure, plus one long hold-off
  always @(posedge clk_i) begin
    m_axis_tready_i <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    wait (rand_sent >= RX_HOLD_AFTER);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    led_status_t got;
    led_status_t exp_s;
    got = led_status_t'(m_axis_tdata_o);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_status.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("[%0t] unexpected result transaction %h", $realtime, m_axis_tdata_o);
      end else begin
        exp_s = pending_status.pop_front();
        checked_cnt++;
        if (got.pattern !== exp_s.pattern || got.enabled !== exp_s.enabled ||
            got.blinking !== exp_s.blinking || got.rd_brt !== exp_s.rd_brt ||
            got.rd_period !== exp_s.rd_period || got.rd_thr !== exp_s.rd_thr) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $write("[%0t] result %0d mismatch: pattern %h/%h enabled %h/%h ",
                   $realtime, checked_cnt,
                   exp_s.pattern, got.pattern, exp_s.enabled, got.enabled);
            $display("blinking %h/%h brt %h/%h period %h/%h thr %h/%h (exp/got)",
                     exp_s.blinking, got.blinking, exp_s.rd_brt, got.rd_brt,
                     exp_s.rd_period, got.rd_period, exp_s.rd_thr, got.rd_thr);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cyc_cnt, pending_status.size());
      $display("FAIL led_pwm_blink_controller");
      $finish;
    end
  end

  initial begin
    led_cmd_t          c;
    logic [FUNC_W-1:0] fn;
    int                pick;
    int                phase;

    dir_tab = '{
      // reset state: everything reads as zero
      '{FUNC_READ, 3'd0, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b1, 64'h0},
      '{FUNC_TICK, 3'd0, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b1, 64'h0},
      '{FUNC_ENABLE, 3'd7, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b1,
        {16'h0, 16'h0, 8'h00, 8'h00, 8'h80, 8'h00}},
      // set brightness is stored without clamping
      '{FUNC_SET_BRT, 3'd7, 8'hff, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_READ, 3'd7, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b1,
        {16'h0, 16'h0, 8'hff, 8'h00, 8'h80, 8'h00}},
      // step saturates at the top and at zero
      '{FUNC_STEP_BRT, 3'd7, 8'h00, 8'h7f, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_READ, 3'd7, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b1,
        {16'h0, 16'h0, 8'(BRIGHTNESS_MAX), 8'h00, 8'h80, 8'h00}},
      '{FUNC_STEP_BRT, 3'd7, 8'h00, 8'h80, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_READ, 3'd7, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b1,
        {16'h0, 16'h0, 8'h00, 8'h00, 8'h80, 8'h00}},
      '{FUNC_SET_BRT, 3'd0, 8'h10, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_TOGGLE, 3'd0, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_TICK, 3'd0, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      // blink period wraps at 16 bits
      '{FUNC_BLINK, 3'd1, 8'h00, 8'h00, 16'hffff, 16'hffff, 8'hff, 16'h0, 16'h0, 1'b0,
        64'h0},
      '{FUNC_READ, 3'd1, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b1,
        {16'hffff, 16'hfffe, 8'h00, 8'h02, 8'h81, 8'h01}},
      // single short run that ends and disables its LED
      '{FUNC_BLINK, 3'd2, 8'h00, 8'h00, 16'h1, 16'h1, 8'h01, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_ENABLE, 3'd2, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_SET_BRT, 3'd2, 8'h10, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_TICK, 3'd0, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_TICK, 3'd0, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      // count of zero repeats forever
      '{FUNC_BLINK, 3'd3, 8'h00, 8'h00, 16'h2, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_PERIOD, 3'd3, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'hffff, 16'h0, 1'b0,
        64'h0},
      '{FUNC_THRESHOLD, 3'd3, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0,
        64'h0},
      // unused codes leave the state alone
      '{FUNC_SPARE_FIRST, 3'd3, 8'hff, 8'h7f, 16'hffff, 16'hffff, 8'hff, 16'hffff,
        16'hffff, 1'b0, 64'h0},
      '{FUNC_SPARE_LAST, 3'd7, 8'hff, 8'h80, 16'hffff, 16'hffff, 8'hff, 16'hffff,
        16'hffff, 1'b0, 64'h0},
      '{FUNC_READ, 3'd3, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0},
      '{FUNC_TICK, 3'd0, 8'h00, 8'h00, 16'h0, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0, 64'h0}
    };

    pwm_cnt   = '0;
    en_mask   = '0;
    blk_mask  = '0;
    rpt_mask  = '0;
    pattern_q = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      brt[i]       = '0;
      btick[i]     = '0;
      bper[i]      = '0;
      lit_thr[i]   = '0;
      runs_left[i] = '0;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      c       = '0;
      c.idx   = dir_tab[k].idx;
      c.bval  = dir_tab[k].bval;
      c.step  = dir_tab[k].step;
      c.on_t  = dir_tab[k].on_t;
      c.off_t = dir_tab[k].off_t;
      c.cnt   = dir_tab[k].cnt;
      c.per   = dir_tab[k].per;
      c.thr   = dir_tab[k].thr;
      send_cmd(dir_tab[k].fn, c, dir_tab[k].typed, led_status_t'(dir_tab[k].want));
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // quiet, sender gaps, receiver stalls, both
      phase = (n * 4) / RAND_ITEMS;
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase

      c = {$urandom, $urandom, $urandom};
      c.pad = '0;
      if ($urandom_range(99) < 75) c.bval = 8'($urandom_range(BRIGHTNESS_MAX + 4));
      if ($urandom_range(99) < 80) begin
        c.on_t  = 16'($urandom_range(4));
        c.off_t = 16'($urandom_range(4));
      end
      if ($urandom_range(99) < 70) c.cnt = 8'($urandom_range(3));
      if ($urandom_range(99) < 80) c.per = 16'($urandom_range(6));
      if ($urandom_range(99) < 80) c.thr = 16'($urandom_range(6));

      pick = $urandom_range(99);
      if (pick < 35)      fn = FUNC_TICK;
      else if (pick < 45) fn = FUNC_ENABLE;
      else if (pick < 50) fn = FUNC_DISABLE;
      else if (pick < 55) fn = FUNC_TOGGLE;
      else if (pick < 62) fn = FUNC_SET_BRT;
      else if (pick < 70) fn = FUNC_STEP_BRT;
      else if (pick < 80) fn = FUNC_BLINK;
      else if (pick < 85) fn = FUNC_PERIOD;
      else if (pick < 90) fn = FUNC_THRESHOLD;
      else if (pick < 97) fn = FUNC_READ;
      else                fn = 4'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));

      send_cmd(fn, c, 1'b0, '0);
      rand_sent++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands (%0d ticks, %0d reads), %0d finite blink runs ended",
             sent_cnt, tick_cnt, read_cnt, runs_done);
    $display("checked %0d results, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0 && pending_status.size() == 0) begin
      $display("PASS led_pwm_blink_controller");
    end else begin
      $display("FAIL led_pwm_blink_controller");
    end
    $finish;
  end

endmodule

[led_pwm_blink_controller.f]
design/led_pwm_pkg.sv
design/led_pwm_blink_controller.sv
design/led_pwm_checker.sv
bench/led_pwm_blink_controller_tb.sv
